/* hw/rtl/sound_channel_control_core_defines.svh */
// Assertion helpers shared by the checker
`ifndef SOUND_CHANNEL_CONTROL_CORE_DEFINES_SVH
`define SOUND_CHANNEL_CONTROL_CORE_DEFINES_SVH

`define SCC_ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("check failed");

`define SCC_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("check failed");

`endif

/* hw/rtl/scc_pkg.sv */
`default_nettype none
package scc_pkg;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam int RegDepth = 48;
    localparam int RegAw    = 6;

    typedef struct packed {
        logic [1:0] op;
        logic [5:0] reg_offset;
        logic [7:0] write_data;
    } in_beat_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [3:0]  channels_on;
        logic [3:0]  volume_one;
        logic [3:0]  volume_two;
        logic [3:0]  volume_four;
        logic [10:0] sweep_period_value;
    } out_beat_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_FLUSH,
        ST_OUT
    } state_t;

    // reset image of the register file, indexed from offset 0x10
    function automatic logic [7:0] reset_byte(input logic [5:0] a);
        logic [7:0] v;
        v = 8'h00;
        case (a)
            6'h00: v = 8'h80; 6'h01: v = 8'hBF; 6'h02: v = 8'hF3;
            6'h04: v = 8'hBF; 6'h06: v = 8'h3F; 6'h07: v = 8'h00;
            6'h09: v = 8'hBF; 6'h0A: v = 8'h7F; 6'h0B: v = 8'hFF;
            6'h0C: v = 8'h9F; 6'h0D: v = 8'hBF; 6'h10: v = 8'hFF;
            6'h11: v = 8'h00; 6'h12: v = 8'h00; 6'h13: v = 8'hBF;
            6'h14: v = 8'h77; 6'h15: v = 8'hF3; 6'h16: v = 8'hF1;
            6'h20: v = 8'hac; 6'h21: v = 8'hdd; 6'h22: v = 8'hda; 6'h23: v = 8'h48;
            6'h24: v = 8'h36; 6'h25: v = 8'h02; 6'h26: v = 8'hcf; 6'h27: v = 8'h16;
            6'h28: v = 8'h2c; 6'h29: v = 8'h04; 6'h2A: v = 8'he5; 6'h2B: v = 8'h2c;
            6'h2C: v = 8'hac; 6'h2D: v = 8'hdd; 6'h2E: v = 8'hda; 6'h2F: v = 8'h48;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // power-off defaults: one bit per offset that is reloaded
    function automatic logic po_hit(input logic [5:0] a);
        logic h;
        case (a)
            6'h00, 6'h01, 6'h02, 6'h04, 6'h06, 6'h07, 6'h09, 6'h0A, 6'h0B,
            6'h0C, 6'h0D, 6'h10, 6'h11, 6'h12, 6'h13, 6'h14, 6'h15, 6'h16:
                h = 1'b1;
            default: h = 1'b0;
        endcase
        return h;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/scc_ram.sv */
`default_nettype none
module scc_ram #(
    parameter int Width = 8,
    parameter int Depth = 48
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] waddr,
    input  wire logic [Width-1:0]         wdata,
    input  wire logic [$clog2(Depth)-1:0] raddr,
    output logic      [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* hw/rtl/sound_channel_control_core.sv */
//  channel | handshake           | payload
//  in      | in_valid/in_stall   | scc_pkg::in_beat_t
//  out     | out_valid/out_stall | scc_pkg::out_beat_t
//  Each beat passes idle, register-file read, execute, result before the next is taken.
//  The result follows the read, execute and any flush state; out_stall holds it there.
//  Writing 0x26 with bit 7 clear adds a flush state that reloads the defaults.
//  After reset a clearing pass loads all 48 RAM entries; no beat is taken.
//  The result waits in the output register; a new beat is taken once it goes.
`default_nettype none
module sound_channel_control_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire scc_pkg::in_beat_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output scc_pkg::out_beat_t      out_data
);
    scc_pkg::state_t state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    scc_pkg::in_beat_t beat_reg;

    // small cached copies of bytes the control logic uses every beat
    logic [7:0] r10_reg, r14_reg, r19_reg, r1a_reg, r1e_reg, r23_reg, r26_reg;
    logic [7:0] e_reg [3];
    logic [7:0] f13_reg;
    logic [6:0] len_reg [3];
    logic [8:0] lenw_reg;
    logic [2:0] ediv_reg [3];
    logic [3:0] vol_reg [3];
    logic [2:0] sdiv_reg;
    logic [10:0] sfreq_reg;
    logic [3:0] en_reg;
    logic [1:0] phase_reg;
    logic [7:0] rd_reg;

    logic                       we;
    logic [scc_pkg::RegAw-1:0]  waddr, raddr;
    logic [7:0]                 wdata, rdata;

    scc_ram #(.Width(8), .Depth(scc_pkg::RegDepth)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    logic [scc_pkg::RegAw-1:0] a;
    assign a = beat_reg.reg_offset - 6'h10;

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        unique case (state_reg)
            scc_pkg::ST_CLEAR:
            begin
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd47)
                    state_next = scc_pkg::ST_IDLE;
            end
            scc_pkg::ST_IDLE:
                if (in_valid)
                    state_next = scc_pkg::ST_READ;
            scc_pkg::ST_READ:
                state_next = scc_pkg::ST_EXEC;
            scc_pkg::ST_EXEC:
            begin
                cnt_next = 6'd0;
                if (beat_reg.op == scc_pkg::OP_WRITE && beat_reg.reg_offset == 6'h26
                        && !beat_reg.write_data[7])
                    state_next = scc_pkg::ST_FLUSH;
                else
                    state_next = scc_pkg::ST_OUT;
            end
            scc_pkg::ST_FLUSH:
            begin
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'h16)
                    state_next = scc_pkg::ST_OUT;
            end
            scc_pkg::ST_OUT:
                if (!out_stall)
                    state_next = scc_pkg::ST_IDLE;
            default:
                state_next = scc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall = (state_reg != scc_pkg::ST_IDLE);
        out_valid = (state_reg == scc_pkg::ST_OUT);
        out_data.read_data = rd_reg;
        out_data.channels_on = en_reg;
        out_data.volume_one = vol_reg[0];
        out_data.volume_two = vol_reg[1];
        out_data.volume_four = vol_reg[2];
        out_data.sweep_period_value = sfreq_reg;
        raddr = (a < 6'd48) ? a : 6'd0;
    end

    // execute: computes next cached state for writes and ticks
    logic        pw;
    logic [7:0]  b;
    logic [11:0] fsum;
    logic [10:0] f1;
    logic [10:0] dlt;
    logic [3:0]  en_n;
    logic [7:0]  r26_n;
    logic [7:0]  e_n [3];
    logic [6:0]  len_n [3];
    logic [8:0]  lenw_n;
    logic [2:0]  ediv_n [3];
    logic [3:0]  vol_n [3];
    logic [2:0]  sdiv_n;
    logic [10:0] sfreq_n;
    logic [2:0]  ep;
    logic [2:0]  dv;
    logic [3:0]  bitk;
    logic        wave_lock;

    always_comb
    begin
        pw = r26_reg[7];
        b = beat_reg.write_data;
        en_n = en_reg;
        r26_n = r26_reg;
        lenw_n = lenw_reg;
        sdiv_n = sdiv_reg;
        sfreq_n = sfreq_reg;
        fsum = 12'd0;
        f1 = {r14_reg[2:0], f13_reg};
        dlt = 11'd0;
        ep = 3'd0;
        dv = 3'd0;
        bitk = 4'd0;
        wave_lock = r26_reg[2] && r1a_reg[7];
        for (int k = 0; k < 3; k++)
        begin
            e_n[k] = e_reg[k];
            len_n[k] = len_reg[k];
            ediv_n[k] = ediv_reg[k];
            vol_n[k] = vol_reg[k];
        end
        if (beat_reg.op == scc_pkg::OP_WRITE && beat_reg.reg_offset >= 6'h10
                && (pw || beat_reg.reg_offset == 6'h26))
        begin
            case (beat_reg.reg_offset)
                6'h10:
                begin
                    sfreq_n = f1;
                    sdiv_n = 3'd0;
                end
                6'h11: len_n[0] = 7'd64 - {1'b0, b[5:0]};
                6'h16: len_n[1] = 7'd64 - {1'b0, b[5:0]};
                6'h20: len_n[2] = 7'd64 - {1'b0, b[5:0]};
                6'h1B: lenw_n = 9'd256 - {1'b0, b};
                6'h12, 6'h17, 6'h21:
                begin
                    bitk = (beat_reg.reg_offset == 6'h12) ? 4'd1 :
                           (beat_reg.reg_offset == 6'h17) ? 4'd2 : 4'd8;
                    for (int k = 0; k < 3; k++)
                        if (bitk == (k == 2 ? 4'd8 : 4'(k + 1)))
                        begin
                            e_n[k] = b;
                            vol_n[k] = b[7:4];
                        end
                    if (b[7:3] == 5'd0)
                    begin
                        en_n = en_n & ~bitk;
                        r26_n = r26_n & ~{4'd0, bitk};
                    end
                end
                6'h1A:
                    if (!b[7])
                    begin
                        en_n[2] = 1'b0;
                        r26_n[2] = 1'b0;
                    end
                6'h1E:
                    if (b[7])
                    begin
                        en_n[2] = 1'b1;
                        r26_n[2] = 1'b1;
                        if (lenw_reg == 9'd0)
                            lenw_n = 9'd256;
                    end
                6'h14, 6'h19, 6'h23:
                    if (b[7])
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            if ((k == 0 && beat_reg.reg_offset == 6'h14)
                                    || (k == 1 && beat_reg.reg_offset == 6'h19)
                                    || (k == 2 && beat_reg.reg_offset == 6'h23))
                            begin
                                bitk = (k == 0) ? 4'd1 : (k == 1) ? 4'd2 : 4'd8;
                                if (k == 2)
                                    en_n[3] = 1'b0;
                                if (e_reg[k][7:3] != 5'd0)
                                begin
                                    r26_n = r26_n | {4'd0, bitk};
                                    en_n = en_n | bitk;
                                    if (len_reg[k] == 7'd0)
                                        len_n[k] = 7'd64;
                                    ediv_n[k] = 3'd0;
                                    vol_n[k] = e_reg[k][7:4];
                                    if (k == 0)
                                    begin
                                        f1 = {b[2:0], f13_reg};
                                        sdiv_n = 3'd0;
                                        fsum = {1'b0, f1};
                                        if (r10_reg[2:0] != 3'd0)
                                        begin
                                            fsum = {1'b0, f1} + {1'b0, f1 >> r10_reg[2:0]};
                                            if (fsum[11])
                                            begin
                                                en_n[0] = 1'b0;
                                                r26_n[0] = 1'b0;
                                            end
                                        end
                                        sfreq_n = fsum[10:0];
                                    end
                                end
                            end
                        end
                    end
                6'h26:
                    r26_n = b;
                default: ;
            endcase
        end
        else if (beat_reg.op == scc_pkg::OP_TICK && pw)
        begin
            if (!phase_reg[0] && r10_reg[6:4] != 3'd0)
            begin
                sdiv_n = sdiv_reg + 3'd1;
                if (sdiv_n == r10_reg[6:4])
                begin
                    sdiv_n = 3'd0;
                    dlt = sfreq_reg >> r10_reg[2:0];
                    if (r10_reg[3])
                        fsum = {1'b0, sfreq_reg} - {1'b0, dlt};
                    else
                    begin
                        fsum = {1'b0, sfreq_reg} + {1'b0, dlt};
                        if (fsum[11])
                        begin
                            en_n[0] = 1'b0;
                            r26_n[0] = 1'b0;
                        end
                    end
                    sfreq_n = fsum[10:0];
                end
            end
            if (r14_reg[6] && len_reg[0] != 7'd0)
            begin
                len_n[0] = len_reg[0] - 7'd1;
                if (len_n[0] == 7'd0)
                begin
                    en_n[0] = 1'b0;
                    r26_n[0] = 1'b0;
                end
            end
            if (r19_reg[6] && len_reg[1] != 7'd0)
            begin
                len_n[1] = len_reg[1] - 7'd1;
                if (len_n[1] == 7'd0)
                begin
                    en_n[1] = 1'b0;
                    r26_n[1] = 1'b0;
                end
            end
            if (r1e_reg[6] && lenw_reg != 9'd0)
            begin
                lenw_n = lenw_reg - 9'd1;
                if (lenw_n == 9'd0)
                begin
                    en_n[2] = 1'b0;
                    r26_n[2] = 1'b0;
                end
            end
            if (r23_reg[6] && len_reg[2] != 7'd0)
            begin
                len_n[2] = len_reg[2] - 7'd1;
                if (len_n[2] == 7'd0)
                begin
                    en_n[3] = 1'b0;
                    r26_n[3] = 1'b0;
                end
            end
            if (phase_reg == 2'd0)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    ep = e_reg[k][2:0];
                    if (en_n[k == 2 ? 3 : k] && ep != 3'd0)
                    begin
                        dv = ediv_reg[k] + 3'd1;
                        ediv_n[k] = dv;
                        if (dv == ep)
                        begin
                            ediv_n[k] = 3'd0;
                            if (e_reg[k][3])
                            begin
                                if (e_reg[k][7:4] != 4'hF)
                                    e_n[k][7:4] = e_reg[k][7:4] + 4'd1;
                            end
                            else if (e_reg[k][7:4] != 4'h0)
                                e_n[k][7:4] = e_reg[k][7:4] - 4'd1;
                            vol_n[k] = e_n[k][7:4];
                        end
                    end
                end
            end
        end
    end

    // unused offsets drop the written byte
    logic store_ok;
    always_comb
    begin
        case (beat_reg.reg_offset) inside
            6'h15, 6'h1F, [6'h27:6'h2F]: store_ok = 1'b0;
            default: store_ok = 1'b1;
        endcase
    end

    logic do_write;
    assign do_write = beat_reg.op == scc_pkg::OP_WRITE && beat_reg.reg_offset >= 6'h10
        && (r26_reg[7] || beat_reg.reg_offset == 6'h26) && store_ok
        && !(beat_reg.reg_offset[5:4] == 2'b11 && wave_lock);

    // single RAM write port: clearing pass, write-back in execute, default reload
    always_comb
    begin
        we = 1'b0;
        waddr = cnt_reg;
        wdata = scc_pkg::reset_byte(cnt_reg);
        unique case (state_reg)
            scc_pkg::ST_CLEAR:
                we = (cnt_reg < 6'd48);
            scc_pkg::ST_EXEC:
            begin
                we = do_write;
                waddr = a;
                wdata = b;
            end
            scc_pkg::ST_FLUSH:
                we = scc_pkg::po_hit(cnt_reg);
            default:
                we = 1'b0;
        endcase
    end

    // envelope bytes and 0x26 live in the cache; reads of them come from there
    logic [7:0] rd_val;
    always_comb
    begin
        case (beat_reg.reg_offset)
            6'h12: rd_val = e_reg[0];
            6'h17: rd_val = e_reg[1];
            6'h21: rd_val = e_reg[2];
            6'h26: rd_val = r26_reg;
            default: rd_val = rdata;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= scc_pkg::ST_CLEAR;
            cnt_reg <= 6'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
        end
    end

    logic [3:0] rstv;
    assign rstv = 4'hF;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r10_reg <= 8'h80; r14_reg <= 8'hBF; r19_reg <= 8'hBF; r1a_reg <= 8'h7F;
            r1e_reg <= 8'h00; r23_reg <= 8'hBF; r26_reg <= 8'hF1; f13_reg <= 8'h00;
            e_reg[0] <= 8'hF3; e_reg[1] <= 8'h00; e_reg[2] <= 8'h00;
            len_reg[0] <= 7'd1; len_reg[1] <= 7'd1; len_reg[2] <= 7'd1;
            lenw_reg <= 9'd1;
            for (int k = 0; k < 3; k++)
                ediv_reg[k] <= 3'd0;
            vol_reg[0] <= rstv; vol_reg[1] <= 4'd0; vol_reg[2] <= 4'd0;
            sdiv_reg <= 3'd0; sfreq_reg <= 11'd0; en_reg <= 4'd0; phase_reg <= 2'd0;
            rd_reg <= 8'd0;
            beat_reg <= '0;
        end
        else
        begin
            if (state_reg == scc_pkg::ST_IDLE && in_valid)
                beat_reg <= in_data;
            if (state_reg == scc_pkg::ST_EXEC)
            begin
                rd_reg <= (beat_reg.op == scc_pkg::OP_READ && beat_reg.reg_offset >= 6'h10)
                    ? rd_val : 8'd0;
                if (do_write)
                begin
                    case (beat_reg.reg_offset)
                        6'h10: r10_reg <= b;
                        6'h13: f13_reg <= b;
                        6'h14: r14_reg <= b;
                        6'h19: r19_reg <= b;
                        6'h1A: r1a_reg <= b;
                        6'h1E: r1e_reg <= b;
                        6'h23: r23_reg <= b;
                        default: ;
                    endcase
                end
                r26_reg <= r26_n; en_reg <= en_n; lenw_reg <= lenw_n;
                sdiv_reg <= sdiv_n; sfreq_reg <= sfreq_n;
                for (int k = 0; k < 3; k++)
                begin
                    e_reg[k] <= e_n[k]; len_reg[k] <= len_n[k];
                    ediv_reg[k] <= ediv_n[k]; vol_reg[k] <= vol_n[k];
                end
                if (beat_reg.op == scc_pkg::OP_TICK && r26_reg[7])
                    phase_reg <= phase_reg + 2'd1;
                if (state_next == scc_pkg::ST_FLUSH)
                begin
                    r10_reg <= 8'h80; r14_reg <= 8'hBF; r19_reg <= 8'hBF;
                    r1a_reg <= 8'h7F; r23_reg <= 8'hBF; r26_reg <= 8'hF1;
                    e_reg[0] <= 8'hF3; e_reg[1] <= 8'h00; e_reg[2] <= 8'h00;
                    len_reg[0] <= 7'd1; len_reg[1] <= 7'd1; len_reg[2] <= 7'd1;
                    lenw_reg <= 9'd1;
                    for (int k = 0; k < 3; k++)
                        ediv_reg[k] <= 3'd0;
                    vol_reg[0] <= rstv; vol_reg[1] <= 4'd0; vol_reg[2] <= 4'd0;
                    sdiv_reg <= 3'd0; sfreq_reg <= 11'd0; en_reg <= 4'd0;
                end
            end
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/scc_checker.sv */
`default_nettype none
`include "sound_channel_control_core_defines.svh"
module scc_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_stall,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire scc_pkg::out_beat_t out_data
);
    `SCC_ASSERT_IMPL(a_busy, clk, rst_n, out_valid, in_stall)
    `SCC_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))
    `SCC_ASSERT_IMPL(a_known, clk, rst_n, out_valid, !$isunknown(out_data))
    `SCC_ASSERT_NEXT(a_take, clk, rst_n, in_valid && !in_stall, !out_valid)
endmodule

bind sound_channel_control_core scc_checker u_scc_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
`default_nettype wire
